>>> design/murmur1_key_hash_top_assert.svh
// Assertion macros for the murmur1 key hash block.
`ifndef MURMUR1_KEY_HASH_TOP_ASSERT_SVH
`define MURMUR1_KEY_HASH_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clk edge out of reset.
`define MURKH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("murkh: same-cycle check failed");

// Next-cycle implication.
`define MURKH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("murkh: next-cycle check failed");

`endif

>>> design/murkh_pkg.sv
// Package: types, constants and helpers for the murmur1 key hash block.
`timescale 1ns / 1ps
`default_nettype none

package murkh_pkg;

    localparam logic [31:0] MUR_MULT       = 32'hc6a4a793;
    localparam logic [31:0] SEED_RESET     = 32'h19900917;
    localparam int unsigned ITEM_Q_DEPTH   = 4;
    localparam int unsigned SHIFT_ROUND    = 16;
    localparam int unsigned SHIFT_FIN1     = 10;
    localparam int unsigned SHIFT_FIN2     = 17;

    typedef struct packed {
        logic [31:0] word;   // key bytes, unused high bytes already cleared
        logic [30:0] len;
        logic        first;
        logic        last;
        logic        rnd;    // word carries at least one byte
    } murkh_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_APPLY
    } murkh_state_t;

    typedef enum logic [1:0] {
        K_INIT,
        K_ROUND,
        K_FIN1,
        K_FIN2
    } murkh_kind_t;

    function automatic logic [31:0] byte_mask(input logic [2:0] nbytes);
        logic [31:0] m;
        begin
            case (nbytes)
                3'd0:    m = 32'h0000_0000;
                3'd1:    m = 32'h0000_00ff;
                3'd2:    m = 32'h0000_ffff;
                3'd3:    m = 32'h00ff_ffff;
                default: m = 32'hffff_ffff;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

>>> design/murkh_front.sv
// Front end: classifies an incoming beat into a queue item.
`timescale 1ns / 1ps
`default_nettype none

module murkh_front
    import murkh_pkg::*;
(
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  bytes_valid,
    input  wire logic        first_word,
    input  wire logic        last_word,
    input  wire logic [30:0] key_length,
    output murkh_item_t      item
);

    always_comb
    begin
        item.word  = data_word & byte_mask(bytes_valid);
        item.len   = key_length;
        item.first = first_word;
        item.last  = last_word;
        item.rnd   = (bytes_valid != 3'd0);
    end

endmodule

`default_nettype wire

>>> design/murkh_item_q.sv
// Small item queue between the front end and the hash engine.
`timescale 1ns / 1ps
`default_nettype none

module murkh_item_q
    import murkh_pkg::*;
#(
    parameter int unsigned DEPTH = ITEM_Q_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire murkh_item_t wr_item,
    output logic       q_full,
    input  wire logic  rd_en,
    output murkh_item_t rd_item,
    output logic       q_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    murkh_item_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

>>> design/murkh_back.sv
// Hash engine: init, word rounds and finalization on one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

module murkh_back
    import murkh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr,
    input  wire logic [31:0] cfg_seed,
    input  wire murkh_item_t item,
    input  wire logic        q_empty,
    output logic             item_pop,
    output logic             res_valid,
    output logic [31:0]      res_hash,
    input  wire logic        res_take
);

    murkh_state_t state_reg, state_next;
    murkh_kind_t  kind_reg, kind_next;
    logic [31:0]  seed_reg;
    logic [31:0]  accum_reg, accum_next;
    logic [31:0]  op_reg, op_next;
    logic [31:0]  prod_reg;
    logic [31:0]  prod_full;
    logic [31:0]  word_reg, word_next;
    logic         rnd_reg, rnd_next;
    logic         last_reg, last_next;
    logic         out_valid_reg, out_valid_next;
    logic [31:0]  out_reg, out_next;
    logic         dispatch, go_rnd, go_last;
    logic [31:0]  base;

    // only the low word of the product is needed
    assign prod_full = op_reg * MUR_MULT;
    assign res_valid = out_valid_reg;
    assign res_hash  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        accum_next     = accum_reg;
        op_next        = op_reg;
        word_next      = word_reg;
        rnd_next       = rnd_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !res_take;
        out_next       = out_reg;
        item_pop       = 1'b0;
        dispatch       = 1'b0;
        go_rnd         = 1'b0;
        go_last        = 1'b0;
        base           = accum_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    item_pop  = 1'b1;
                    word_next = item.word;
                    rnd_next  = item.rnd;
                    last_next = item.last;
                    if (item.first)
                    begin
                        op_next    = {1'b0, item.len};
                        kind_next  = K_INIT;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        dispatch = 1'b1;
                        go_rnd   = item.rnd;
                        go_last  = item.last;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                case (kind_reg)
                    K_INIT:
                    begin
                        accum_next = seed_reg ^ prod_reg;
                        base       = accum_next;
                        dispatch   = 1'b1;
                        go_rnd     = rnd_reg;
                        go_last    = last_reg;
                    end
                    K_ROUND:
                    begin
                        accum_next = prod_reg ^ (prod_reg >> SHIFT_ROUND);
                        base       = accum_next;
                        dispatch   = 1'b1;
                        go_last    = last_reg;
                    end
                    K_FIN1:
                    begin
                        op_next    = prod_reg ^ (prod_reg >> SHIFT_FIN1);
                        kind_next  = K_FIN2;
                        state_next = ST_MUL;
                    end
                    K_FIN2:
                    begin
                        // hold here until the result register frees up
                        if (!out_valid_reg || res_take)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = prod_reg ^ (prod_reg >> SHIFT_FIN2);
                            state_next     = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // finalization works on a copy; the accumulator keeps its value
        if (dispatch)
        begin
            if (go_rnd)
            begin
                op_next    = base + word_next;
                kind_next  = K_ROUND;
                state_next = ST_MUL;
            end
            else if (go_last)
            begin
                op_next    = base;
                kind_next  = K_FIN1;
                state_next = ST_MUL;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= K_INIT;
            seed_reg      <= SEED_RESET;
            accum_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            accum_reg     <= accum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                seed_reg <= cfg_seed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        prod_reg <= prod_full;
        word_reg <= word_next;
        rnd_reg  <= rnd_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

>>> design/murmur1_key_hash_top.sv
// Top level of the murmur1 key hash block: front end, item queue, hash engine.
`timescale 1ns / 1ps
`default_nettype none

// Streams a key as 32-bit little-endian words and returns its 32-bit murmur1 hash
// after the beat marked last_word. Beats enter an item queue of ITEM_Q_DEPTH entries,
// so push is taken whenever full is low. The hash engine uses one shared 32x32
// multiplier with a registered operand and product. Each item is dispatched; a first word
// also runs the length init, a word with bytes runs a word round, and a last word runs
// finalization. The result sits in an output register until popped; the engine
// stalls only when a second hash is ready before the first is taken.
// The seed may be rewritten through cfg_valid/cfg_ready while the block is idle.

module murmur1_key_hash_top
    import murkh_pkg::*;
#(
    parameter int unsigned ITEM_Q_DEPTH_P = ITEM_Q_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] hash_seed,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  bytes_valid,
    input  wire logic        first_word,
    input  wire logic        last_word,
    input  wire logic [30:0] key_length,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      hash_value
);

    murkh_item_t in_item;
    murkh_item_t q_item;
    logic        q_empty;
    logic        item_pop;
    logic        res_valid;

    assign cfg_ready = 1'b1;
    assign empty     = !res_valid;

    murkh_front u_front (
        .data_word   (data_word),
        .bytes_valid (bytes_valid),
        .first_word  (first_word),
        .last_word   (last_word),
        .key_length  (key_length),
        .item        (in_item)
    );

    murkh_item_q #(
        .DEPTH (ITEM_Q_DEPTH_P)
    ) u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_item (in_item),
        .q_full  (full),
        .rd_en   (item_pop),
        .rd_item (q_item),
        .q_empty (q_empty)
    );

    murkh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_seed  (hash_seed),
        .item      (q_item),
        .q_empty   (q_empty),
        .item_pop  (item_pop),
        .res_valid (res_valid),
        .res_hash  (hash_value),
        .res_take  (pop)
    );

`include "murmur1_key_hash_top_assert.svh"

    // engine never pulls from an empty queue
    `MURKH_ASSERT_NOW(a_pop_not_empty, item_pop, !q_empty)
    // a beat written into an empty queue is visible to the engine next cycle
    `MURKH_ASSERT_NEXT(a_push_fills, push && !full && q_empty, !q_empty)
    // a full queue stays full unless the engine drains it
    `MURKH_ASSERT_NEXT(a_full_holds, full && !item_pop, full)

endmodule

`default_nettype wire

>>> tb/sv/murkh_hash_checker.sv
// Checker for the murmur1 key hash block: predicts each hash and compares it at the result port.
`timescale 1ns / 1ps

module murkh_hash_checker
    import murkh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [31:0]       hash_seed,
    input  logic              push,
    input  logic              full,
    input  logic [31:0]       data_word,
    input  logic [2:0]        bytes_valid,
    input  logic              first_word,
    input  logic              last_word,
    input  logic [30:0]       key_length,
    input  logic              empty,
    input  logic              pop,
    input  logic [31:0]       hash_value,
    output int unsigned       hashes_due,
    output int unsigned       mismatches
);

    logic [31:0] seed_q;
    logic [31:0] accum_q;
    logic [31:0] hash_due_q[$];

    function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] t;
        t = (h + k) * MUR_MULT;
        return t ^ (t >> 16);
    endfunction

    function automatic logic [31:0] finish_hash(input logic [31:0] h);
        logic [31:0] t;
        t = h * MUR_MULT;
        t = t ^ (t >> 10);
        t = t * MUR_MULT;
        return t ^ (t >> 17);
    endfunction

    // Keeps the low n bytes of a tail word, n in 1..3.
    function automatic logic [31:0] tail_mask(input logic [2:0] n);
        return ~(32'hffff_ffff << {n, 3'b000});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] acc;
        logic [31:0] want;
        if (!rst_n)
        begin
            seed_q     <= SEED_RESET;
            accum_q    <= '0;
            hash_due_q.delete();
            hashes_due <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                seed_q <= hash_seed;

            // result side first, so a beat accepted this edge cannot satisfy it
            if (pop && !empty)
            begin
                if (hash_due_q.size() == 0)
                begin
                    $error("hash_value: no hash expected, actual %h", hash_value);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = hash_due_q.pop_front();
                    if (hash_value !== want)
                    begin
                        $error("hash_value mismatch: expected %h, actual %h", want, hash_value);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            acc = accum_q;
            if (push && !full)
            begin
                if (first_word)
                    acc = seed_q ^ ({1'b0, key_length} * MUR_MULT);
                if (bytes_valid >= 3'd4)
                    acc = mix_word(acc, data_word);
                else if (bytes_valid != 3'd0)
                    acc = mix_word(acc, data_word & tail_mask(bytes_valid));
                // finalization works on a copy; the accumulator keeps its value
                if (last_word)
                    hash_due_q.push_back(finish_hash(acc));
            end
            accum_q    <= acc;
            hashes_due <= hash_due_q.size();
        end
    end

endmodule

>>> tb/sv/murmur1_key_hash_top_tb.sv
// Testbench top for the murmur1 key hash block: stimulus, result drain and verdict.
`timescale 1ns / 1ps

module murmur1_key_hash_top_tb;

    import murkh_pkg::*;

    localparam int SETTLE_CYCLES = 48;
    localparam int PHASE_ITEMS   = 100;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_COIN,
        POP_SPARSE,
        POP_SQUARE
    } pop_style_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [31:0] hash_seed   = '0;
    logic        push        = 1'b0;
    logic [31:0] data_word   = '0;
    logic [2:0]  bytes_valid = '0;
    logic        first_word  = 1'b0;
    logic        last_word   = 1'b0;
    logic [30:0] key_length  = '0;
    logic        pop         = 1'b0;
    logic        cfg_ready;
    logic        full;
    logic        empty;
    logic [31:0] hash_value;

    int unsigned hashes_due;
    int unsigned mismatches;
    int          burst_left = 0;
    pop_style_t  pop_style  = POP_ALWAYS;
    logic [5:0]  pop_tick   = '0;

    murmur1_key_hash_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .hash_seed   (hash_seed),
        .push        (push),
        .full        (full),
        .data_word   (data_word),
        .bytes_valid (bytes_valid),
        .first_word  (first_word),
        .last_word   (last_word),
        .key_length  (key_length),
        .empty       (empty),
        .pop         (pop),
        .hash_value  (hash_value)
    );

    murkh_hash_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .hash_seed   (hash_seed),
        .push        (push),
        .full        (full),
        .data_word   (data_word),
        .bytes_valid (bytes_valid),
        .first_word  (first_word),
        .last_word   (last_word),
        .key_length  (key_length),
        .empty       (empty),
        .pop         (pop),
        .hash_value  (hash_value),
        .hashes_due  (hashes_due),
        .mismatches  (mismatches)
    );

    always #2 clk = ~clk;

    initial
    begin
        #(2_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: a new style is drawn each time pop_tick wraps, including a stall-free one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            pop_tick <= '0;
        end
        else
        begin
            pop_tick <= pop_tick + 1'b1;
            if (pop_tick == '0)
                pop_style <= pop_style_t'($urandom_range(0, 3));
            case (pop_style)
                POP_ALWAYS: pop <= 1'b1;
                POP_COIN:   pop <= 1'($urandom_range(0, 1));
                POP_SPARSE: pop <= ($urandom_range(0, 7) == 0);
                POP_SQUARE: pop <= pop_tick[3];
                default:    pop <= 1'b1;
            endcase
        end
    end

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hffff_ffff;
        return $urandom();
    endfunction

    // One input beat; the sender idles between bursts of random length.
    task automatic send_beat(input logic [31:0] d, input logic [2:0] nb, input logic f,
                             input logic l, input logic [30:0] len);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 32);
        end
        data_word   <= d;
        bytes_valid <= nb;
        first_word  <= f;
        last_word   <= l;
        key_length  <= len;
        push        <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (hashes_due != 0)
            @(posedge clk);
        // beats without a result may still be in the engine
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] s);
        drain_results();
        cfg_valid <= 1'b1;
        hash_seed <= s;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int n_items);
        int          sent;
        int          len;
        int          nwords;
        logic [2:0]  nb;
        logic [30:0] klen;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                // well-formed key, length usually honest
                len    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                     : $urandom_range(0, 24);
                nwords = (len == 0) ? 1 : (len + 3) / 4;
                klen   = ($urandom_range(0, 9) == 0) ? 31'($urandom()) : 31'(len);
                for (int i = 0; i < nwords; i++)
                begin
                    if (i < nwords - 1)
                        nb = 3'd4;
                    else if (len == 0)
                        nb = 3'd0;
                    else
                        nb = ((len % 4) == 0) ? 3'd4 : 3'(len % 4);
                    send_beat(rand_word(), nb, i == 0, i == nwords - 1, klen);
                    sent++;
                end
            end
            else
            begin
                // broken framing: any flags, any byte count
                repeat ($urandom_range(1, 4))
                begin
                    send_beat(rand_word(), 3'($urandom_range(0, 7)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              31'($urandom()));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed keys under the reset seed
        send_beat(32'h0, 3'd0, 1'b1, 1'b1, 31'd0);                    // empty key
        send_beat(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 31'd1);
        send_beat(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 31'd2);
        send_beat(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 31'd3);
        send_beat(32'h0, 3'd4, 1'b1, 1'b1, 31'd4);
        send_beat(32'hffff_ffff, 3'd4, 1'b1, 1'b0, 31'd8);
        send_beat(32'hffff_ffff, 3'd4, 1'b0, 1'b1, 31'd8);
        send_beat(32'h1234_5678, 3'd5, 1'b1, 1'b1, 31'd4);            // oversized counts
        send_beat(32'h8765_4321, 3'd6, 1'b1, 1'b1, 31'd4);
        send_beat(32'hdead_beef, 3'd7, 1'b1, 1'b1, 31'd4);
        send_beat(32'haaaa_5555, 3'd2, 1'b1, 1'b0, 31'd6);            // tail not last
        send_beat(32'h5555_aaaa, 3'd4, 1'b0, 1'b1, 31'd6);
        send_beat(32'hcafe_f00d, 3'd4, 1'b0, 1'b1, 31'd4);            // no first beat
        send_beat(32'h0, 3'd0, 1'b1, 1'b1, 31'h7fff_ffff);            // max length
        send_beat(32'h0102_0304, 3'd4, 1'b1, 1'b1, 31'd100);          // length mismatch
        send_beat(32'hffff_ffff, 3'd4, 1'b1, 1'b0, 31'h5555_5555);
        send_beat(32'hffff_ffff, 3'd0, 1'b0, 1'b0, 31'h2aaa_aaaa);    // zero bytes mid-key
        send_beat(32'h00c0_ffee, 3'd3, 1'b0, 1'b1, 31'd7);
        send_beat(32'h1357_9bdf, 3'd4, 1'b0, 1'b0, 31'd0);            // neither flag
        send_beat(32'h2468_ace0, 3'd1, 1'b0, 1'b1, 31'd0);
        send_beat(32'h0, 3'd0, 1'b0, 1'b1, 31'd0);                    // re-finalize only

        write_seed(32'h0000_0000);
        random_traffic(PHASE_ITEMS);
        write_seed(32'hffff_ffff);
        random_traffic(PHASE_ITEMS);
        write_seed($urandom());
        random_traffic(PHASE_ITEMS);
        write_seed(SEED_RESET ^ $urandom());
        random_traffic(PHASE_ITEMS);

        drain_results();
        if (mismatches == 0 && hashes_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/murkh_pkg.sv
design/murkh_front.sv
design/murkh_item_q.sv
design/murkh_back.sv
design/murmur1_key_hash_top.sv
tb/sv/murkh_hash_checker.sv
tb/sv/murmur1_key_hash_top_tb.sv
